// ===== design/nhls_pkg.sv =====
package nhls_pkg;

    localparam int FEATURE_COUNT    = 4096;
    localparam int NGRAM_MAX        = 8;
    localparam int HASH_BASE        = 131;

    localparam int WEIGHT_W         = 32;
    localparam int WEIGHT_ADDR_W    = 12;
    localparam int LOGIT_W          = 40;
    localparam int NGRAM_CFG_W      = 4;
    localparam int NGRAM_SIZE_RESET = 3;

    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NGRAM_SIZE = 1'd0,
        CFG_INTERCEPT  = 1'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_WRITE_WEIGHT = 2'd0,
        OP_URL_BYTE     = 2'd1,
        OP_URL_END      = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_ACC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        opcode_t                     opcode;
        logic [WEIGHT_ADDR_W-1:0]    weight_addr;
        logic signed [WEIGHT_W-1:0]  weight_value;
        logic [7:0]                  url_byte;
        logic                        url_end;
    } scorer_in_t;

    typedef struct packed {
        logic signed [LOGIT_W-1:0]   logit_value;
        logic                        too_short;
        logic                        saturated;
    } scorer_out_t;

endpackage

// ===== design/ngram_hash_linear_scorer.sv =====
// Hashed character n-gram scorer for URL strings.
// Requests enter on in_valid/in_ready as scorer_in_t items: a weight write
// stores one signed Q16.16 weight, a URL byte extends the current URL (url_end
// closes it), and an end request closes the URL with no byte. One score leaves
// on out_valid/out_ready per closed URL as a saturated Q24.16 logit.
// ngram_size and intercept_value are written on cfg_valid/cfg_data, which is
// always ready; write them only while no URL result is pending.
// A weight write or a byte before the window fills is taken in the idle state;
// a byte that forms a full window then runs the Horner hash unit, one base-131
// step per cycle over the last n bytes (n = effective n-gram size), then one
// weight memory read and one saturating accumulate. Closing a URL goes through
// an emit state that loads the score into the output register once it is free.
// The result sits in an output register, so new requests are taken while it
// waits; a stalled receiver only holds up the next URL close.
// Reset clears the sequencer, the per-URL state and the output valid, and sets
// ngram_size to 3 and intercept_value to 0. The weight memory is not cleared:
// every weight must be written before a URL can read it.
module ngram_hash_linear_scorer #(
    parameter int FEATURE_COUNT = nhls_pkg::FEATURE_COUNT,
    parameter int NGRAM_MAX     = nhls_pkg::NGRAM_MAX
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  nhls_pkg::scorer_in_t                in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output nhls_pkg::scorer_out_t               out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nhls_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nhls_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ABITS  = $clog2(FEATURE_COUNT);
    localparam int CNT_W  = $clog2(NGRAM_MAX + 1);
    localparam int IDX_W  = (NGRAM_MAX > 1) ? $clog2(NGRAM_MAX) : 1;
    localparam int LW     = nhls_pkg::LOGIT_W;
    localparam int WW     = nhls_pkg::WEIGHT_W;
    localparam logic [ABITS-1:0] HashBase = ABITS'(nhls_pkg::HASH_BASE);

    nhls_pkg::state_t           state_reg, state_next;
    logic [7:0]                 window_reg [NGRAM_MAX];
    logic [7:0]                 window_next [NGRAM_MAX];
    logic [CNT_W-1:0]           bytes_seen_reg, bytes_seen_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [ABITS-1:0]           hash_reg, hash_next;
    logic signed [LW-1:0]       acc_reg, acc_next;
    logic                       clip_reg, clip_next;
    logic                       url_end_reg, url_end_next;
    logic [nhls_pkg::NGRAM_CFG_W-1:0] ngram_size_reg;
    logic signed [WW-1:0]       intercept_reg;
    logic                       out_valid_reg, out_valid_next;
    nhls_pkg::scorer_out_t      out_data_reg, out_data_next;

    logic [CNT_W-1:0]           n_eff;
    logic [CNT_W-1:0]           win_sel;
    logic                       in_fire;
    logic                       ram_wr_en;
    logic                       ram_rd_en;
    logic [ABITS-1:0]           ram_rd_addr;
    logic [WW-1:0]              ram_rd_data;
    logic [LW:0]                acc_sum;
    logic [LW:0]                emit_sum;

    function automatic logic [LW:0] sat_add(
        input logic signed [LW-1:0] a,
        input logic signed [WW-1:0] b
    );
        logic signed [LW:0] sum;
        logic [LW:0]        res;
        sum = $signed({a[LW-1], a}) + $signed({{(LW + 1 - WW){b[WW-1]}}, b});
        if (sum[LW] != sum[LW-1])
        begin
            res = {1'b1, sum[LW], {(LW - 1){~sum[LW]}}};
        end
        else
        begin
            res = {1'b0, sum[LW-1:0]};
        end
        return res;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == nhls_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the configured size into 1..NGRAM_MAX.
    always_comb
    begin
        if (ngram_size_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(ngram_size_reg) > NGRAM_MAX)
        begin
            n_eff = CNT_W'(NGRAM_MAX);
        end
        else
        begin
            n_eff = CNT_W'(ngram_size_reg);
        end
    end

    assign ram_wr_en = in_fire && (in_data.opcode == nhls_pkg::OP_WRITE_WEIGHT)
                       && (int'(in_data.weight_addr) < FEATURE_COUNT);

    nhls_ram #(
        .WIDTH (WW),
        .DEPTH (FEATURE_COUNT)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ABITS'(in_data.weight_addr)),
        .wr_data (in_data.weight_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign win_sel  = cnt_reg - CNT_W'(1);
    assign acc_sum  = sat_add(acc_reg, $signed(ram_rd_data));
    assign emit_sum = sat_add(acc_reg, intercept_reg);

    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        bytes_seen_next = bytes_seen_reg;
        cnt_next        = cnt_reg;
        hash_next       = hash_reg;
        acc_next        = acc_reg;
        clip_next       = clip_reg;
        url_end_next    = url_end_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = hash_reg;

        unique case (state_reg)
            nhls_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_data.opcode)
                        nhls_pkg::OP_URL_BYTE:
                        begin
                            window_next[0] = in_data.url_byte;
                            for (int k = 1; k < NGRAM_MAX; k++)
                            begin
                                window_next[k] = window_reg[k-1];
                            end
                            if (bytes_seen_reg < CNT_W'(NGRAM_MAX))
                            begin
                                bytes_seen_next = bytes_seen_reg + CNT_W'(1);
                            end
                            url_end_next = in_data.url_end;
                            if (bytes_seen_next >= n_eff)
                            begin
                                cnt_next   = n_eff;
                                hash_next  = '0;
                                state_next = nhls_pkg::ST_HASH;
                            end
                            else if (in_data.url_end)
                            begin
                                state_next = nhls_pkg::ST_EMIT;
                            end
                        end
                        nhls_pkg::OP_URL_END:
                        begin
                            state_next = nhls_pkg::ST_EMIT;
                        end
                        default:
                        begin
                            // weight writes go straight to memory; drop unused codes
                        end
                    endcase
                end
            end
            nhls_pkg::ST_HASH:
            begin
                // one Horner step per cycle, oldest byte first
                hash_next = hash_reg * HashBase + ABITS'(window_reg[win_sel[IDX_W-1:0]]);
                cnt_next  = win_sel;
                if (cnt_reg == CNT_W'(1))
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = hash_next;
                    state_next  = nhls_pkg::ST_ACC;
                end
            end
            nhls_pkg::ST_ACC:
            begin
                acc_next  = $signed(acc_sum[LW-1:0]);
                clip_next = clip_reg || acc_sum[LW];
                state_next = url_end_reg ? nhls_pkg::ST_EMIT : nhls_pkg::ST_IDLE;
            end
            nhls_pkg::ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (bytes_seen_reg < n_eff)
                    begin
                        out_data_next.logit_value = LW'(intercept_reg);
                        out_data_next.too_short   = 1'b1;
                        out_data_next.saturated   = 1'b0;
                    end
                    else
                    begin
                        out_data_next.logit_value = $signed(emit_sum[LW-1:0]);
                        out_data_next.too_short   = 1'b0;
                        out_data_next.saturated   = clip_reg || emit_sum[LW];
                    end
                    bytes_seen_next = '0;
                    hash_next       = '0;
                    acc_next        = '0;
                    clip_next       = 1'b0;
                    url_end_next    = 1'b0;
                    state_next      = nhls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nhls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nhls_pkg::ST_IDLE;
            bytes_seen_reg <= '0;
            cnt_reg        <= '0;
            hash_reg       <= '0;
            acc_reg        <= '0;
            clip_reg       <= 1'b0;
            url_end_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            ngram_size_reg <= nhls_pkg::NGRAM_CFG_W'(nhls_pkg::NGRAM_SIZE_RESET);
            intercept_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            bytes_seen_reg <= bytes_seen_next;
            cnt_reg        <= cnt_next;
            hash_reg       <= hash_next;
            acc_reg        <= acc_next;
            clip_reg       <= clip_next;
            url_end_reg    <= url_end_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (nhls_pkg::cfg_index_t'(cfg_index))
                    nhls_pkg::CFG_NGRAM_SIZE:
                        ngram_size_reg <= cfg_data[nhls_pkg::NGRAM_CFG_W-1:0];
                    nhls_pkg::CFG_INTERCEPT:
                        intercept_reg <= $signed(cfg_data[WW-1:0]);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg   <= window_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== design/nhls_ram.sv =====
module nhls_ram #(
    parameter int WIDTH = nhls_pkg::WEIGHT_W,
    parameter int DEPTH = nhls_pkg::FEATURE_COUNT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/nhls_checker.sv =====
module nhls_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input nhls_pkg::scorer_in_t  in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input nhls_pkg::scorer_out_t out_data,
    input logic                  cfg_ready
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output result changed while stalled");

    // a short URL never reports clipping
    a_short_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.too_short |-> !out_data.saturated)
        else $error("too_short and saturated both set");

    // in the cycle after a weight write the scorer is ready again
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.opcode == nhls_pkg::OP_WRITE_WEIGHT)
        |=> in_ready)
        else $error("not ready after a weight write");

    // an end request always leaves the scorer busy in the next cycle producing the score
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.opcode == nhls_pkg::OP_URL_END)
        |=> !in_ready)
        else $error("ready right after an end request");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind ngram_hash_linear_scorer nhls_checker u_nhls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
